FILE: hw/rtl/partition_extent_table_unit_defines.svh
// Assertion macros shared by the partition extent table RTL.
// No dependencies; included by the files that carry assertions.
`ifndef PARTITION_EXTENT_TABLE_UNIT_DEFINES_SVH
`define PARTITION_EXTENT_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PET_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PET_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/pet_pkg.sv
// Shared types and constants of the partition extent table.
// No dependencies; imported by every module of the block.
package pet_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = IDX_W + 1;
    localparam int ID_W        = 6;
    localparam int CFG_IDX_W   = 2;

    // remainder unit: 34-bit dividend, divisor up to 65536
    localparam int DVD_W  = 34;
    localparam int DVS_W  = 17;
    localparam int STEP_W = $clog2(DVD_W + 1);

    localparam logic [2:0] MODE_INSERT = 3'd0;
    localparam logic [2:0] MODE_ALLOC  = 3'd1;
    localparam logic [2:0] MODE_DELETE = 3'd2;
    localparam logic [2:0] MODE_TOGGLE = 3'd3;
    localparam logic [2:0] MODE_CLEAR  = 3'd4;
    localparam logic [2:0] MODE_READ   = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_ALIGN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISK  = 2'd1;

    localparam logic [CNT_W-1:0] PRI_LIMIT     = CNT_W'(4);
    localparam logic [CNT_W-1:0] PRI_LIMIT_LOG = CNT_W'(3);
    localparam logic [ID_W-1:0]  FIRST_LOG_ID  = ID_W'(5);
    localparam logic [ID_W-1:0]  LAST_PRI_ID   = ID_W'(4);

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_REJECT   = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] size;
        logic [31:0] rsv;
        logic [1:0]  slot;
        logic        active;
        logic        logical;
    } t_entry;

    typedef struct packed {
        t_status          status;
        logic [IDX_W-1:0] idx;
        t_entry           ent;
    } t_result;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mod_stat;

    typedef enum logic [4:0] {
        S_IDLE, S_SCAN_RD, S_SCAN_EV, S_DECIDE,
        S_GAP_RD, S_GAP_EV, S_MOD_FROM, S_MOD_LEN, S_GAP_CHK,
        S_SH_RD, S_SH_WR, S_PUT, S_DEL_RD, S_DEL_WR, S_RD_WAIT, S_DONE
    } t_state;

endpackage

FILE: hw/rtl/partition_extent_table_unit.sv
// Partition extent table: command sequencer, scan logic and gap allocator.
// Depends on pet_pkg, pet_table, pet_mod_unit and the assertion macro header.
//
// Usage: a command transfer on the input channel (i_in_valid / o_in_ready)
// carries mode and operands; exactly one result transfer follows on the
// output channel (o_out_valid / i_out_ready). Configuration writes go on
// the cfg channel (index 0: alignment minus one, index 1: disk size) and
// are always ready; write them only while the block is idle.
// Clear and bad modes go straight to the result; read waits for the
// registered table read. Insert, delete, toggle and allocate first run
// a summary scan over the table; insert then shifts entries up and
// delete shifts them down through the table's one read and one write
// port, while toggle rewrites the found entry in place. Allocate adds a
// gap walk and, for every gap that passes size and type checks, two runs
// of the bit-serial remainder unit before it shifts entries up as well.
// o_in_ready is high only in the idle state; a new command is taken while
// the previous result still waits, and its result is held until the
// output register frees. After reset (synchronous, active low) the table
// is empty and both configuration registers are zero.
`include "partition_extent_table_unit_defines.svh"
module partition_extent_table_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [2:0]                    i_mode,
    input  logic                          i_part_type,
    input  logic [1:0]                    i_primary_slot,
    input  logic [31:0]                   i_start_block,
    input  logic [31:0]                   i_block_count,
    input  logic [31:0]                   i_reserved_blocks,
    input  logic                          i_active_flag,
    input  logic [pet_pkg::ID_W-1:0]      i_part_id,
    input  logic [pet_pkg::IDX_W-1:0]     i_entry_index,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_status,
    output logic [pet_pkg::IDX_W-1:0]     o_out_index,
    output logic                          o_out_type,
    output logic [1:0]                    o_out_slot,
    output logic [31:0]                   o_out_start,
    output logic [31:0]                   o_out_size,
    output logic [31:0]                   o_out_reserved,
    output logic                          o_out_active,
    output logic [pet_pkg::CNT_W-1:0]     o_entry_count,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pet_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);
    import pet_pkg::*;

    // control state
    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_out_valid, n_out_valid;

    // configuration
    logic [15:0]       r_align_m1;
    logic [31:0]       r_disk;

    // captured command
    logic [2:0]        r_mode, n_mode;
    logic              r_logical, n_logical;
    logic [1:0]        r_pslot, n_pslot;
    logic [31:0]       r_st, n_st;
    logic [31:0]       r_sz, n_sz;
    logic [31:0]       r_rs, n_rs;
    logic              r_act, n_act;
    logic [ID_W-1:0]   r_id, n_id;

    // scan and sequencing
    logic [CNT_W-1:0]  r_i, n_i;
    logic [CNT_W-1:0]  r_k, n_k;
    logic [CNT_W-1:0]  r_pos, n_pos;
    logic [CNT_W-1:0]  r_pcnt, n_pcnt;
    logic [CNT_W-1:0]  r_lseen, n_lseen;
    logic              r_havelog, n_havelog;
    logic [3:0]        r_slots, n_slots;
    logic              r_found, n_found;
    logic [IDX_W-1:0]  r_fpos, n_fpos;
    t_entry            r_fent, n_fent;
    logic              r_ifound, n_ifound;
    logic              r_ovl, n_ovl;
    logic              r_lastlog, n_lastlog;
    logic              r_curlog, n_curlog;

    // gap walk
    logic [32:0]       r_gstart, n_gstart;
    logic              r_gplog, n_gplog;
    logic [32:0]       r_nstart, n_nstart;
    logic              r_nplog, n_nplog;
    logic              r_final, n_final;
    logic [DVD_W-1:0]  r_from_num, n_from_num;
    logic [DVD_W-1:0]  r_from, n_from;
    logic [31:0]       r_len, n_len;

    t_entry            r_new, n_new;
    t_result           r_res, n_res;
    t_result           r_out, n_out;
    logic [CNT_W-1:0]  r_out_cnt, n_out_cnt;

    // table and remainder unit hookup
    logic              tbl_we;
    logic [IDX_W-1:0]  tbl_waddr, tbl_raddr;
    t_entry            tbl_wdata, rd;
    logic              mod_start;
    logic [DVD_W-1:0]  mod_dvd;
    t_mod_stat         mod_stat;
    logic [DVS_W-1:0]  mod_rem;

    // helpers
    logic [DVS_W-1:0]  align;
    logic              pfree;
    logic [1:0]        free_slot;
    logic [32:0]       e_end, ins_end, lim, avail;
    logic              prev_log, next_log, type_ok, size_ok, eval;
    logic [31:0]       len_num;
    logic [DVD_W:0]    fit_end;
    logic              chk_fail;
    t_entry            tog;

    pet_table u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_raddr (tbl_raddr),
        .o_rdata (rd)
    );

    pet_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (mod_dvd),
        .i_divisor  (align),
        .o_stat     (mod_stat),
        .o_rem      (mod_rem)
    );

    assign align       = {1'b0, r_align_m1} + 1'b1;
    assign pfree       = r_pcnt < (r_havelog ? PRI_LIMIT_LOG : PRI_LIMIT);
    assign free_slot   = !r_slots[0] ? 2'd0 : !r_slots[1] ? 2'd1 : !r_slots[2] ? 2'd2 : 2'd3;
    assign e_end       = {1'b0, rd.start} + {1'b0, rd.size};
    assign ins_end     = {1'b0, r_st} + {1'b0, r_sz};
    assign lim         = r_final ? {1'b0, r_disk} : {1'b0, rd.start};
    assign avail       = (lim > r_gstart) ? (lim - r_gstart) : 33'd0;
    assign eval        = r_final || (r_sz != '0);
    assign size_ok     = {1'b0, r_sz} <= avail;
    assign prev_log    = r_gplog;
    assign next_log    = !r_final && rd.logical;
    assign len_num     = (r_sz != '0) ? r_sz : avail[31:0];
    assign fit_end     = {1'b0, r_from} + {3'b0, r_len};
    assign chk_fail    = (r_len == '0) || (fit_end > {3'b0, r_disk})
                      || (r_logical && (r_len <= {15'b0, align}));

    always_comb begin
        if (!r_logical) begin
            type_ok = pfree && !(prev_log && next_log);
        end else if (!r_havelog) begin
            type_ok = pfree;
        end else begin
            type_ok = prev_log || next_log;
        end
        tog        = r_fent;
        tog.active = !r_fent.active;
    end

    always_comb begin
        n_state = r_state;   n_cnt = r_cnt;       n_out_valid = r_out_valid;
        n_mode = r_mode;     n_logical = r_logical; n_pslot = r_pslot;
        n_st = r_st;         n_sz = r_sz;         n_rs = r_rs;
        n_act = r_act;       n_id = r_id;
        n_i = r_i;           n_k = r_k;           n_pos = r_pos;
        n_pcnt = r_pcnt;     n_lseen = r_lseen;   n_havelog = r_havelog;
        n_slots = r_slots;   n_found = r_found;   n_fpos = r_fpos;
        n_fent = r_fent;     n_ifound = r_ifound; n_ovl = r_ovl;
        n_lastlog = r_lastlog; n_curlog = r_curlog;
        n_gstart = r_gstart; n_gplog = r_gplog;   n_nstart = r_nstart;
        n_nplog = r_nplog;   n_final = r_final;   n_from_num = r_from_num;
        n_from = r_from;     n_len = r_len;       n_new = r_new;
        n_res = r_res;       n_out = r_out;       n_out_cnt = r_out_cnt;
        tbl_we = 1'b0;       tbl_waddr = '0;      tbl_wdata = rd;
        tbl_raddr = '0;      mod_start = 1'b0;    mod_dvd = r_from_num;

        // drop the shown result once it is taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                tbl_raddr = i_entry_index;
                if (i_in_valid) begin
                    n_mode = i_mode;       n_logical = i_part_type;
                    n_pslot = i_primary_slot; n_st = i_start_block;
                    n_sz = i_block_count;  n_rs = i_reserved_blocks;
                    n_act = i_active_flag; n_id = i_part_id;
                    n_res = '0;
                    n_i = '0;     n_pcnt = '0;   n_lseen = '0;  n_havelog = 1'b0;
                    n_slots = '0; n_found = 1'b0; n_ifound = 1'b0; n_ovl = 1'b0;
                    n_lastlog = 1'b0; n_curlog = 1'b0; n_pos = r_cnt;
                    n_state = S_SCAN_RD;
                    case (i_mode)
                        MODE_CLEAR: begin
                            n_cnt   = '0;
                            n_state = S_DONE;
                        end
                        MODE_READ: begin
                            if ({1'b0, i_entry_index} >= r_cnt) begin
                                n_res.status = ST_NOTFOUND;
                                n_state      = S_DONE;
                            end else begin
                                n_pos   = {1'b0, i_entry_index};
                                n_state = S_RD_WAIT;
                            end
                        end
                        MODE_INSERT, MODE_ALLOC: begin
                            if (r_cnt >= CNT_W'(MAX_ENTRIES)) begin
                                n_res.status = ST_FULL;
                                n_state      = S_DONE;
                            end
                        end
                        MODE_DELETE, MODE_TOGGLE: begin
                        end
                        default: begin
                            n_res.status = ST_REJECT;
                            n_state      = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN_RD: begin
                tbl_raddr = r_i[IDX_W-1:0];
                n_state   = (r_i == r_cnt) ? S_DECIDE : S_SCAN_EV;
            end
            S_SCAN_EV: begin
                if (rd.logical) begin
                    n_havelog = 1'b1;
                    n_lseen   = r_lseen + 1'b1;
                    if (!r_found && r_id >= FIRST_LOG_ID
                        && ID_W'(r_lseen + 1'b1) == (r_id - LAST_PRI_ID)) begin
                        n_found = 1'b1; n_fpos = r_i[IDX_W-1:0]; n_fent = rd;
                    end
                end else begin
                    n_pcnt           = r_pcnt + 1'b1;
                    n_slots[rd.slot] = 1'b1;
                    if (!r_found && r_id != '0 && r_id <= LAST_PRI_ID
                        && {4'b0, rd.slot} == (r_id - 1'b1)) begin
                        n_found = 1'b1; n_fpos = r_i[IDX_W-1:0]; n_fent = rd;
                    end
                end
                // overlap check stops at the first extent past the new one or at the first overlap
                if (!r_ifound && !r_ovl) begin
                    if ({1'b0, rd.start} >= ins_end) begin
                        n_ifound = 1'b1; n_pos = r_i; n_curlog = rd.logical;
                    end else begin
                        if (e_end > {1'b0, r_st}) begin
                            n_ovl = 1'b1;
                        end
                        n_lastlog = rd.logical;
                    end
                end
                n_i     = r_i + 1'b1;
                n_state = S_SCAN_RD;
            end
            S_DECIDE: begin
                n_state = S_DONE;
                case (r_mode)
                    MODE_INSERT: begin
                        if ((!r_logical && (!pfree || r_slots[r_pslot])) || r_ovl
                            || (r_logical && r_havelog && !(r_lastlog || r_curlog))) begin
                            n_res.status = ST_REJECT;
                        end else begin
                            n_new.start   = r_st;
                            n_new.size    = r_sz;
                            n_new.rsv     = r_rs;
                            n_new.slot    = r_logical ? 2'd0 : r_pslot;
                            n_new.active  = r_act;
                            n_new.logical = r_logical;
                            n_k           = r_cnt;
                            n_state       = S_SH_RD;
                        end
                    end
                    MODE_ALLOC: begin
                        n_i      = '0;
                        n_gstart = 33'd1;
                        n_gplog  = 1'b0;
                        n_state  = S_GAP_RD;
                    end
                    MODE_TOGGLE: begin
                        if (!r_found) begin
                            n_res.status = ST_NOTFOUND;
                        end else begin
                            tbl_we    = 1'b1;
                            tbl_waddr = r_fpos;
                            tbl_wdata = tog;
                            n_res.idx = r_fpos;
                            n_res.ent = tog;
                        end
                    end
                    default: begin
                        if (!r_found) begin
                            n_res.status = ST_NOTFOUND;
                        end else begin
                            n_res.idx = r_fpos;
                            n_res.ent = r_fent;
                            n_k       = {1'b0, r_fpos};
                            n_state   = S_DEL_RD;
                        end
                    end
                endcase
            end
            S_GAP_RD: begin
                tbl_raddr = r_i[IDX_W-1:0];
                n_final   = (r_i == r_cnt);
                n_state   = S_GAP_EV;
            end
            S_GAP_EV: begin
                n_nstart   = e_end;
                n_nplog    = rd.logical;
                n_pos      = r_i;
                mod_dvd    = {1'b0, r_gstart} + {18'b0, r_align_m1};
                if (eval && size_ok && type_ok) begin
                    mod_start  = 1'b1;
                    n_from_num = mod_dvd;
                    n_len      = len_num;
                    n_state    = S_MOD_FROM;
                end else if (r_final) begin
                    n_res.status = ST_REJECT;
                    n_state      = S_DONE;
                end else begin
                    n_gstart = e_end;
                    n_gplog  = rd.logical;
                    n_i      = r_i + 1'b1;
                    n_state  = S_GAP_RD;
                end
            end
            S_MOD_FROM: begin
                mod_dvd = {2'b0, r_len};
                if (mod_stat.done) begin
                    // round the start up to the granule
                    n_from    = r_from_num - {{(DVD_W-DVS_W){1'b0}}, mod_rem};
                    mod_start = 1'b1;
                    n_state   = S_MOD_LEN;
                end
            end
            S_MOD_LEN: begin
                if (mod_stat.done) begin
                    n_len   = r_len - {15'b0, mod_rem};
                    n_state = S_GAP_CHK;
                end
            end
            S_GAP_CHK: begin
                if (chk_fail) begin
                    if (r_final) begin
                        n_res.status = ST_REJECT;
                        n_state      = S_DONE;
                    end else begin
                        n_gstart = r_nstart;
                        n_gplog  = r_nplog;
                        n_i      = r_i + 1'b1;
                        n_state  = S_GAP_RD;
                    end
                end else begin
                    n_new.start   = r_from[31:0];
                    n_new.size    = r_len;
                    n_new.rsv     = r_logical ? {15'b0, align} : 32'd0;
                    n_new.slot    = r_logical ? 2'd0 : free_slot;
                    n_new.active  = 1'b0;
                    n_new.logical = r_logical;
                    n_k           = r_cnt;
                    n_state       = S_SH_RD;
                end
            end
            S_SH_RD: begin
                tbl_raddr = IDX_W'(r_k - 1'b1);
                n_state   = (r_k == r_pos) ? S_PUT : S_SH_WR;
            end
            S_SH_WR: begin
                // move one entry up to open the slot
                tbl_we    = 1'b1;
                tbl_waddr = r_k[IDX_W-1:0];
                tbl_wdata = rd;
                n_k       = r_k - 1'b1;
                n_state   = S_SH_RD;
            end
            S_PUT: begin
                tbl_we    = 1'b1;
                tbl_waddr = r_pos[IDX_W-1:0];
                tbl_wdata = r_new;
                n_cnt     = r_cnt + 1'b1;
                n_res.idx = r_pos[IDX_W-1:0];
                n_res.ent = r_new;
                n_state   = S_DONE;
            end
            S_DEL_RD: begin
                tbl_raddr = IDX_W'(r_k + 1'b1);
                if ((r_k + 1'b1) >= r_cnt) begin
                    n_cnt   = r_cnt - 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_DEL_WR;
                end
            end
            S_DEL_WR: begin
                tbl_we    = 1'b1;
                tbl_waddr = r_k[IDX_W-1:0];
                tbl_wdata = rd;
                n_k       = r_k + 1'b1;
                n_state   = S_DEL_RD;
            end
            S_RD_WAIT: begin
                n_res.idx = r_pos[IDX_W-1:0];
                n_res.ent = rd;
                n_state   = S_DONE;
            end
            S_DONE: begin
                // hold the result until the output register frees
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_cnt   = r_cnt;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_align_m1  <= '0;
            r_disk      <= '0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && i_cfg_index == CFG_ALIGN) begin
                r_align_m1 <= i_cfg_data[15:0];
            end
            if (i_cfg_valid && i_cfg_index == CFG_DISK) begin
                r_disk <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode <= n_mode;     r_logical <= n_logical; r_pslot <= n_pslot;
        r_st <= n_st;         r_sz <= n_sz;           r_rs <= n_rs;
        r_act <= n_act;       r_id <= n_id;
        r_i <= n_i;           r_k <= n_k;             r_pos <= n_pos;
        r_pcnt <= n_pcnt;     r_lseen <= n_lseen;     r_havelog <= n_havelog;
        r_slots <= n_slots;   r_found <= n_found;     r_fpos <= n_fpos;
        r_fent <= n_fent;     r_ifound <= n_ifound;   r_ovl <= n_ovl;
        r_lastlog <= n_lastlog; r_curlog <= n_curlog;
        r_gstart <= n_gstart; r_gplog <= n_gplog;     r_nstart <= n_nstart;
        r_nplog <= n_nplog;   r_final <= n_final;     r_from_num <= n_from_num;
        r_from <= n_from;     r_len <= n_len;         r_new <= n_new;
        r_res <= n_res;       r_out <= n_out;         r_out_cnt <= n_out_cnt;
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out.status;
    assign o_out_index    = r_out.idx;
    assign o_out_type     = r_out.ent.logical;
    assign o_out_slot     = r_out.ent.slot;
    assign o_out_start    = r_out.ent.start;
    assign o_out_size     = r_out.ent.size;
    assign o_out_reserved = r_out.ent.rsv;
    assign o_out_active   = r_out.ent.active;
    assign o_entry_count  = r_out_cnt;

    `PET_ASSERT_NOW(a_cnt_bound, i_clk, i_rst_n, 1'b1, (r_cnt <= CNT_W'(MAX_ENTRIES)),
        "entry count above table depth")
    `PET_ASSERT_NEXT(a_cnt_stable, i_clk, i_rst_n,
        (r_state != S_IDLE && r_state != S_PUT && r_state != S_DEL_RD),
        $stable(r_cnt), "entry count changed outside put, delete or clear")
    `PET_ASSERT_NOW(a_mod_running, i_clk, i_rst_n,
        (r_state == S_MOD_FROM || r_state == S_MOD_LEN),
        (mod_stat.busy || mod_stat.done), "waiting on an idle remainder unit")

endmodule

FILE: hw/rtl/pet_table.sv
// Extent storage: one write port, one registered read port.
// Depends on pet_pkg.
module pet_table (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [pet_pkg::IDX_W-1:0] i_waddr,
    input  pet_pkg::t_entry       i_wdata,
    input  logic [pet_pkg::IDX_W-1:0] i_raddr,
    output pet_pkg::t_entry       o_rdata
);
    import pet_pkg::*;

    t_entry mem [MAX_ENTRIES];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/pet_mod_unit.sv
// Bit-serial remainder unit, one dividend bit per cycle.
// Depends on pet_pkg and the assertion macro header.
`include "partition_extent_table_unit_defines.svh"
module pet_mod_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [pet_pkg::DVD_W-1:0] i_dividend,
    input  logic [pet_pkg::DVS_W-1:0] i_divisor,
    output pet_pkg::t_mod_stat        o_stat,
    output logic [pet_pkg::DVS_W-1:0] o_rem
);
    import pet_pkg::*;

    logic [STEP_W-1:0] r_steps;
    logic              r_done;
    logic [DVD_W-1:0]  r_dvd;
    logic [DVS_W-1:0]  r_dvs;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W:0]    trial;
    logic [DVS_W-1:0]  n_rem;

    always_comb begin
        trial = {r_rem, r_dvd[DVD_W-1]};
        if (trial >= {1'b0, r_dvs}) begin
            n_rem = DVS_W'(trial - {1'b0, r_dvs});
        end else begin
            n_rem = DVS_W'(trial);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps <= '0;
            r_done  <= 1'b0;
        end else if (i_start) begin
            r_steps <= STEP_W'(DVD_W);
            r_done  <= 1'b0;
        end else if (r_steps != '0) begin
            r_steps <= r_steps - 1'b1;
            r_done  <= (r_steps == STEP_W'(1));
        end else begin
            r_done  <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_steps != '0) begin
            r_dvd <= r_dvd << 1;
            r_rem <= n_rem;
        end
    end

    assign o_stat.busy = (r_steps != '0);
    assign o_stat.done = r_done;
    assign o_rem       = r_rem;

    `PET_ASSERT_NOW(a_rem_below_divisor, i_clk, i_rst_n, r_done, (r_rem < r_dvs),
        "remainder not below divisor")
    `PET_ASSERT_NOW(a_done_idle, i_clk, i_rst_n, r_done, (r_steps == '0),
        "done while still stepping")
    `PET_ASSERT_NEXT(a_start_loads, i_clk, i_rst_n, i_start, (r_steps == STEP_W'(DVD_W)),
        "start did not load the step count")

endmodule
